### rtl/crhp_pkg.sv
// ----------------------------------------------------------------------------
// crhp_pkg
// shared types, character codes and helpers for the content-range parser
// ----------------------------------------------------------------------------
`default_nettype none

package crhp_pkg;

  localparam int NUM_W    = 64;
  localparam int UNIT_LEN = 5;

  typedef logic [NUM_W-1:0] num_t;

  typedef enum logic [3:0] {
    PH_LEAD        = 4'd0,
    PH_UNIT        = 4'd1,
    PH_PRE_START   = 4'd2,
    PH_START       = 4'd3,
    PH_AFTER_START = 4'd4,
    PH_PRE_END     = 4'd5,
    PH_END         = 4'd6,
    PH_AFTER_END   = 4'd7,
    PH_PRE_TOTAL   = 4'd8,
    PH_TOTAL       = 4'd9,
    PH_TRAIL       = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_UNSUPPORTED = 2'd1,
    ST_INVALID     = 2'd2,
    ST_OVERFLOW    = 2'd3
  } status_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOWER = 8'h20;

  // lower-case letters of the unit word
  function automatic logic [7:0] unit_letter(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return (ch == CH_SPACE) || (ch == CH_TAB);
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

### rtl/crhp_stream_if.sv
// ----------------------------------------------------------------------------
// crhp_stream_if
// valid/ready channels for header characters and parsed ranges
// ----------------------------------------------------------------------------
`default_nettype none

interface crhp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       char_valid;
  logic       last_item;

  modport source (output valid, output char_code, output char_valid,
                  output last_item, input ready);
  modport sink   (input valid, input char_code, input char_valid,
                  input last_item, output ready);
endinterface

interface crhp_range_if import crhp_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  num_t       range_start;
  num_t       range_end;
  num_t       range_total;

  modport source (output valid, output status, output range_start,
                  output range_end, output range_total, input ready);
  modport sink   (input valid, input status, input range_start,
                  input range_end, input range_total, output ready);
endinterface

`default_nettype wire

### rtl/crhp_dec_acc.sv
// ----------------------------------------------------------------------------
// crhp_dec_acc
// decimal digit accumulate step with exact overflow detection
// ----------------------------------------------------------------------------
`default_nettype none

module crhp_dec_acc import crhp_pkg::*; (
  input  wire num_t       acc,
  input  wire logic [3:0] digit,
  output num_t            sum,
  output logic            ovf
);

  logic [NUM_W+3:0] wide;

  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
  assign wide = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{NUM_W{1'b0}}, digit};
  assign sum  = wide[NUM_W-1:0];
  assign ovf  = |wide[NUM_W+3:NUM_W];

endmodule

`default_nettype wire

### rtl/content_range_header_parser.sv
// ----------------------------------------------------------------------------
// content_range_header_parser
// streaming parser for "bytes start-end/total" header values
//
// in_chan carries one character of the header value per transfer, with
// char_valid low for an empty closing item and last_item marking the end
// of the value. Every item is registered on entry and then handled by
// the phase logic and a shared decimal accumulate unit.
// out_chan carries one result per value, on the item with last_item set:
// status, start, end and total (all ones when unknown or '*'); on error
// the three numbers are zero.
// Throughput is one item per cycle unless a final item waits. A result
// passes through the input register and then the result register. The
// next value may follow at once. When out_chan stalls, the result
// register holds; non-final items keep flowing, and a final item waits in
// the input register until the result register frees up, which then
// back-pressures in_chan.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to the leading-blank phase with no error pending.
// ----------------------------------------------------------------------------
`default_nettype none

module content_range_header_parser import crhp_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  crhp_char_if.sink   in_chan,
  crhp_range_if.source out_chan
);

  // input register
  logic       s1_vld_r;
  logic [7:0] s1_code_r;
  logic       s1_cv_r;
  logic       s1_last_r;
  logic       s1_go;
  logic       in_rdy;

  // parser state
  phase_t     phase_r,  phase_nxt;
  logic [2:0] idx_r,    idx_nxt;
  num_t       start_r,  start_nxt;
  num_t       end_r,    end_nxt;
  num_t       total_r,  total_nxt;
  logic       unk_r,    unk_nxt;
  status_t    err_r,    err_nxt;
  status_t    fin_err;

  // result register
  logic       out_vld_r;
  status_t    out_status_r;
  num_t       out_start_r;
  num_t       out_end_r;
  num_t       out_total_r;

  // shared digit unit
  num_t       acc_sel;
  num_t       acc_sum;
  logic       acc_ovf;
  logic [7:0] ch;
  logic       ch_blank;
  logic       ch_digit;
  logic [2:0] idx_eff;

  assign s1_go  = s1_vld_r && (!s1_last_r || !out_vld_r || out_chan.ready);
  assign in_rdy = !s1_vld_r || s1_go;
  assign in_chan.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_rdy) begin
      s1_vld_r <= in_chan.valid;
    end
    if (in_rdy && in_chan.valid) begin
      s1_code_r <= in_chan.char_code;
      s1_cv_r   <= in_chan.char_valid;
      s1_last_r <= in_chan.last_item;
    end
  end

  assign ch       = s1_code_r;
  assign ch_blank = is_blank(ch);
  assign ch_digit = is_digit(ch);
  assign idx_eff  = (phase_r == PH_LEAD) ? 3'd0 : idx_r;

  always_comb begin
    case (phase_r) inside
      PH_PRE_START, PH_START: acc_sel = start_r;
      PH_PRE_END, PH_END:     acc_sel = end_r;
      default:                acc_sel = total_r;
    endcase
  end

  crhp_dec_acc u_dec_acc (
    .acc   (acc_sel),
    .digit (ch[3:0]),
    .sum   (acc_sum),
    .ovf   (acc_ovf)
  );

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    total_nxt = total_r;
    unk_nxt   = unk_r;
    err_nxt   = err_r;

    if (s1_cv_r && (err_r == ST_OK)) begin
      unique case (phase_r) inside
        PH_LEAD, PH_UNIT: begin
          if (!((phase_r == PH_LEAD) && ch_blank)) begin
            phase_nxt = PH_UNIT;
            idx_nxt   = idx_eff;
            if (idx_eff < 3'(UNIT_LEN)) begin
              if ((ch | CH_LOWER) == unit_letter(idx_eff)) begin
                idx_nxt = idx_eff + 3'd1;
              end else begin
                err_nxt = ST_UNSUPPORTED;
              end
            end else if (ch_blank) begin
              phase_nxt = PH_PRE_START;
            end else begin
              err_nxt = ST_UNSUPPORTED;
            end
          end
        end
        PH_PRE_START: begin
          if (ch_digit) begin
            phase_nxt = PH_START;
            if (acc_ovf) err_nxt = ST_OVERFLOW;
            else start_nxt = acc_sum;
          end else if (!ch_blank) begin
            err_nxt = ST_INVALID;
          end
        end
        PH_START, PH_AFTER_START: begin
          if ((phase_r == PH_START) && ch_digit) begin
            if (acc_ovf) err_nxt = ST_OVERFLOW;
            else start_nxt = acc_sum;
          end else if (ch_blank) begin
            phase_nxt = PH_AFTER_START;
          end else if (ch == CH_DASH) begin
            phase_nxt = PH_PRE_END;
          end else begin
            err_nxt = ST_INVALID;
          end
        end
        PH_PRE_END: begin
          if (ch_digit) begin
            phase_nxt = PH_END;
            if (acc_ovf) err_nxt = ST_OVERFLOW;
            else end_nxt = acc_sum;
          end else if (!ch_blank) begin
            err_nxt = ST_INVALID;
          end
        end
        PH_END: begin
          if (ch_digit) begin
            if (acc_ovf) err_nxt = ST_OVERFLOW;
            else end_nxt = acc_sum;
          end else if (end_r < start_r) begin
            err_nxt = ST_INVALID;
          end else if (ch_blank) begin
            phase_nxt = PH_AFTER_END;
          end else if (ch == CH_SLASH) begin
            phase_nxt = PH_PRE_TOTAL;
          end else begin
            err_nxt = ST_INVALID;
          end
        end
        PH_AFTER_END: begin
          if (ch == CH_SLASH) begin
            phase_nxt = PH_PRE_TOTAL;
          end else if (!ch_blank) begin
            err_nxt = ST_INVALID;
          end
        end
        PH_PRE_TOTAL: begin
          if (ch == CH_STAR) begin
            phase_nxt = PH_TRAIL;
          end else if (ch_digit) begin
            phase_nxt = PH_TOTAL;
            unk_nxt   = 1'b0;
            if (acc_ovf) err_nxt = ST_OVERFLOW;
            else total_nxt = acc_sum;
          end else if (!ch_blank) begin
            err_nxt = ST_INVALID;
          end
        end
        PH_TOTAL: begin
          if (ch_digit) begin
            if (acc_ovf) err_nxt = ST_OVERFLOW;
            else total_nxt = acc_sum;
          end else if (total_r < end_r) begin
            err_nxt = ST_INVALID;
          end else begin
            phase_nxt = PH_TRAIL;
            if (!ch_blank) err_nxt = ST_INVALID;
          end
        end
        default: begin
          if (!ch_blank) err_nxt = ST_INVALID;
        end
      endcase
    end

    // end-of-value checks
    fin_err = err_nxt;
    if (err_nxt == ST_OK) begin
      unique case (phase_nxt) inside
        PH_LEAD, PH_UNIT:       fin_err = ST_UNSUPPORTED;
        PH_PRE_TOTAL, PH_TRAIL: fin_err = ST_OK;
        PH_TOTAL:               fin_err = (total_nxt < end_nxt) ? ST_INVALID : ST_OK;
        default:                fin_err = ST_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      idx_r   <= 3'd0;
      start_r <= '0;
      end_r   <= '0;
      total_r <= '0;
      unk_r   <= 1'b1;
      err_r   <= ST_OK;
    end else if (s1_go) begin
      if (s1_last_r) begin
        phase_r <= PH_LEAD;
        idx_r   <= 3'd0;
        start_r <= '0;
        end_r   <= '0;
        total_r <= '0;
        unk_r   <= 1'b1;
        err_r   <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        idx_r   <= idx_nxt;
        start_r <= start_nxt;
        end_r   <= end_nxt;
        total_r <= total_nxt;
        unk_r   <= unk_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
    if (s1_go && s1_last_r) begin
      out_status_r <= fin_err;
      if (fin_err == ST_OK) begin
        out_start_r <= start_nxt;
        out_end_r   <= end_nxt;
        out_total_r <= unk_nxt ? {NUM_W{1'b1}} : total_nxt;
      end else begin
        out_start_r <= '0;
        out_end_r   <= '0;
        out_total_r <= '0;
      end
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.range_start = out_start_r;
  assign out_chan.range_end   = out_end_r;
  assign out_chan.range_total = out_total_r;

endmodule

`default_nettype wire
